// ===== rtl/mkdp_pkg.sv =====
// Package for the multi-key debounce and press classifier.
// Holds field widths, item and register codes, flag positions and shared structs.
// No dependencies.
package mkdp_pkg;

    localparam int MAX_KEYS_DEF = 16;
    localparam int RAW_W        = 16;
    localparam int KEY_IDX_W    = 4;
    localparam int FLAG_W       = 4;
    localparam int KCNT_W       = 5;
    localparam int BOUNCE_W     = 8;
    localparam int HOLD_W       = 16;
    localparam int TICKS_W      = 15;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [BOUNCE_W-1:0] BOUNCE_MAX = {BOUNCE_W{1'b1}};
    localparam logic [HOLD_W-1:0]   HOLD_MAX   = {HOLD_W{1'b1}};

    localparam int FLAG_PRESSED = 0;
    localparam int FLAG_SHORT   = 1;
    localparam int FLAG_LONG    = 2;
    localparam int FLAG_REPEAT  = 3;

    localparam logic [KCNT_W-1:0]   RST_KEY_COUNT  = 5'd0;
    localparam logic [RAW_W-1:0]    RST_ACTIVE_LOW = 16'd0;
    localparam logic [BOUNCE_W-1:0] RST_DEBOUNCE   = 8'd3;
    localparam logic [TICKS_W-1:0]  RST_LONG       = 15'd100;
    localparam logic [TICKS_W-1:0]  RST_REPEAT     = 15'd10;

    typedef enum logic [1:0] {
        KIND_SCAN      = 2'd0,
        KIND_READ      = 2'd1,
        KIND_CLEAR_ALL = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_COUNT  = 3'd0,
        CFG_ACTIVE_LOW = 3'd1,
        CFG_DEBOUNCE   = 3'd2,
        CFG_LONG       = 3'd3,
        CFG_REPEAT     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [BOUNCE_W-1:0] debounce_ticks;
        logic [TICKS_W-1:0]  long_press_ticks;
        logic [TICKS_W-1:0]  repeat_ticks;
    } timing_t;

    typedef struct packed {
        logic              scan;
        logic              clear_all;
        logic              read_clear;
        logic [FLAG_W-1:0] clear_mask;
    } key_ctrl_t;

endpackage

// ===== rtl/mkdp_key.sv =====
// One key of the classifier: debounce counter, hold timer and sticky event flags.
// Depends on mkdp_pkg.
module mkdp_key
    import mkdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  timing_t           timing,
    input  key_ctrl_t         ctrl,
    input  logic              level,
    output logic              stable_next_out,
    output logic [FLAG_W-1:0] flags
);

    logic                stable_reg, stable_next;
    logic                prev_reg, prev_next;
    logic [BOUNCE_W-1:0] bounce_reg, bounce_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic                long_reg, long_next;
    logic [FLAG_W-1:0]   flags_reg, flags_next;

    logic [BOUNCE_W-1:0] bounce_inc;
    logic [HOLD_W-1:0]   hold_inc;
    logic [HOLD_W:0]     repeat_limit;
    logic                scan_stable;
    logic                long_now;

    always_comb
    begin
        bounce_inc   = (bounce_reg == BOUNCE_MAX) ? bounce_reg : bounce_reg + 1'b1;
        hold_inc     = (hold_reg == HOLD_MAX) ? hold_reg : hold_reg + 1'b1;
        repeat_limit = {2'b00, timing.long_press_ticks} + {2'b00, timing.repeat_ticks};

        stable_next = stable_reg;
        prev_next   = prev_reg;
        bounce_next = bounce_reg;
        hold_next   = hold_reg;
        long_next   = long_reg;
        flags_next  = flags_reg;
        scan_stable = stable_reg;
        long_now    = long_reg;

        if (ctrl.scan)
        begin
            if (level == stable_reg)
            begin
                bounce_next = '0;
            end
            else if (bounce_inc >= timing.debounce_ticks)
            begin
                scan_stable = level;
                bounce_next = '0;
            end
            else
            begin
                bounce_next = bounce_inc;
            end
            stable_next = scan_stable;

            if (scan_stable)
            begin
                if (!prev_reg)
                begin
                    prev_next                = 1'b1;
                    hold_next                = '0;
                    long_next                = 1'b0;
                    flags_next[FLAG_PRESSED] = 1'b1;
                end
                else
                begin
                    hold_next = hold_inc;
                    if (!long_reg && (hold_inc >= {1'b0, timing.long_press_ticks}))
                    begin
                        long_now              = 1'b1;
                        flags_next[FLAG_LONG] = 1'b1;
                    end
                    long_next = long_now;
                    if (long_now && ({1'b0, hold_inc} >= repeat_limit))
                    begin
                        flags_next[FLAG_REPEAT] = 1'b1;
                        hold_next               = {1'b0, timing.long_press_ticks};
                    end
                end
            end
            else if (prev_reg)
            begin
                prev_next = 1'b0;
                if (!long_reg)
                begin
                    flags_next[FLAG_SHORT] = 1'b1;
                end
                hold_next = '0;
                long_next = 1'b0;
            end
        end
        else if (ctrl.clear_all)
        begin
            flags_next = '0;
        end
        else if (ctrl.read_clear)
        begin
            flags_next = flags_reg & ~ctrl.clear_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            prev_reg   <= 1'b0;
            bounce_reg <= '0;
            hold_reg   <= '0;
            long_reg   <= 1'b0;
            flags_reg  <= '0;
        end
        else
        begin
            stable_reg <= stable_next;
            prev_reg   <= prev_next;
            bounce_reg <= bounce_next;
            hold_reg   <= hold_next;
            long_reg   <= long_next;
            flags_reg  <= flags_next;
        end
    end

    assign stable_next_out = stable_next;
    assign flags           = flags_reg;

endmodule

// ===== rtl/multi_key_debounce_press_classifier.sv =====
// Multi-key debounce and press classifier, top level.
// Pipeline: input register, then result register; both hold while the output is stalled.
// Throughput: one item per cycle unless output stalls; in-use keys update in their per-key cells.
// Reset: asynchronous active-low; all key state and flags clear, registers take their defaults.
// Depends on mkdp_pkg and mkdp_key.
module multi_key_debounce_press_classifier
    import mkdp_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            kind,
    input  logic [RAW_W-1:0]      raw_levels,
    input  logic [KEY_IDX_W-1:0]  key_index,
    input  logic [FLAG_W-1:0]     clear_mask,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [RAW_W-1:0]      pressed_mask,
    output logic                  key_down,
    output logic                  flag_pressed,
    output logic                  flag_short,
    output logic                  flag_long,
    output logic                  flag_repeat,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [KCNT_W-1:0]    key_count_reg;
    logic [RAW_W-1:0]     active_low_reg;
    timing_t              timing_reg;

    logic                 in_valid_reg;
    logic [1:0]           kind_reg;
    logic [RAW_W-1:0]     raw_reg;
    logic [KEY_IDX_W-1:0] index_reg;
    logic [FLAG_W-1:0]    clear_reg;

    logic                 out_valid_reg;
    logic [RAW_W-1:0]     pressed_reg, pressed_next;
    logic                 down_reg, down_next;
    logic [FLAG_W-1:0]    flags_out_reg, flags_out_next;

    logic                 advance;
    logic [MAX_KEYS-1:0]  in_use;
    logic [MAX_KEYS-1:0]  read_hit;
    logic [MAX_KEYS-1:0]  stable_next;
    logic [FLAG_W-1:0]    key_flags [MAX_KEYS];
    key_ctrl_t            key_ctrl [MAX_KEYS];

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg               <= RST_KEY_COUNT;
            active_low_reg              <= RST_ACTIVE_LOW;
            timing_reg.debounce_ticks   <= RST_DEBOUNCE;
            timing_reg.long_press_ticks <= RST_LONG;
            timing_reg.repeat_ticks     <= RST_REPEAT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_COUNT:  key_count_reg               <= cfg_data[KCNT_W-1:0];
                CFG_ACTIVE_LOW: active_low_reg              <= cfg_data[RAW_W-1:0];
                CFG_DEBOUNCE:   timing_reg.debounce_ticks   <= cfg_data[BOUNCE_W-1:0];
                CFG_LONG:       timing_reg.long_press_ticks <= cfg_data[TICKS_W-1:0];
                CFG_REPEAT:     timing_reg.repeat_ticks     <= cfg_data[TICKS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg  <= kind;
            raw_reg   <= raw_levels;
            index_reg <= key_index;
            clear_reg <= clear_mask;
        end
    end

    for (genvar i = 0; i < MAX_KEYS; i++)
    begin : g_key
        assign in_use[i]   = (KCNT_W'(i) < key_count_reg);
        assign read_hit[i] = in_use[i] && (index_reg == KEY_IDX_W'(i));

        always_comb
        begin
            key_ctrl[i].scan       = advance && in_use[i] && (kind_reg == KIND_SCAN);
            key_ctrl[i].clear_all  = advance && in_use[i] && (kind_reg == KIND_CLEAR_ALL);
            key_ctrl[i].read_clear = advance && read_hit[i] && (kind_reg == KIND_READ);
            key_ctrl[i].clear_mask = clear_reg;
        end

        mkdp_key u_key
        (
            .clk             (clk),
            .rst_n           (rst_n),
            .timing          (timing_reg),
            .ctrl            (key_ctrl[i]),
            .level           (raw_reg[i] ^ active_low_reg[i]),
            .stable_next_out (stable_next[i]),
            .flags           (key_flags[i])
        );
    end

    always_comb
    begin
        pressed_next   = '0;
        down_next      = 1'b0;
        flags_out_next = '0;
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            pressed_next[i] = stable_next[i] && in_use[i];
            if (read_hit[i] && (kind_reg == KIND_READ))
            begin
                down_next      = stable_next[i];
                flags_out_next = key_flags[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pressed_reg   <= pressed_next;
            down_reg      <= down_next;
            flags_out_reg <= flags_out_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pressed_mask = pressed_reg;
    assign key_down     = down_reg;
    assign flag_pressed = flags_out_reg[FLAG_PRESSED];
    assign flag_short   = flags_out_reg[FLAG_SHORT];
    assign flag_long    = flags_out_reg[FLAG_LONG];
    assign flag_repeat  = flags_out_reg[FLAG_REPEAT];

endmodule
